// ===== src/greedy_change_dispenser_macros.svh =====
// Assertion macros for the greedy change dispenser.
// Included by the top level; needs nothing else.
`ifndef GREEDY_CHANGE_DISPENSER_MACROS_SVH
`define GREEDY_CHANGE_DISPENSER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GCD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define GCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/gcd_pkg.sv =====
// Package for the greedy change dispenser: payload structs, codes,
// controller/datapath command and status structs. No dependencies.
package gcd_pkg;

    localparam int AMT_W   = 16;
    localparam int SLOTS   = 4;
    localparam int DIV_CW  = $clog2(AMT_W);
    localparam int CFG_IW  = 3;

    // input actions
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_DISPENSE = 2'd0;
    localparam logic [1:0] KIND_SUMMARY  = 2'd1;
    localparam logic [1:0] KIND_LOAD_ACK = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_DENOM_0 = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_DENOM_1 = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_DENOM_2 = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DENOM_3 = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_IN_USE  = 3'd4;

    // reset values
    localparam logic [AMT_W-1:0] DENOM_0_RST = 16'd1000;
    localparam logic [AMT_W-1:0] DENOM_1_RST = 16'd500;
    localparam logic [AMT_W-1:0] DENOM_2_RST = 16'd100;
    localparam logic [AMT_W-1:0] DENOM_3_RST = 16'd50;
    localparam logic [2:0]       IN_USE_RST  = 3'd4;

    typedef struct packed {
        logic             action;
        logic [1:0]       slot;
        logic [AMT_W-1:0] amount_or_count;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic [AMT_W-1:0] denom_value;
        logic [AMT_W-1:0] piece_count;
        logic [AMT_W-1:0] remaining;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic load_stock;   // write stock of the accepted load
        logic start_req;    // capture amount, clear cursor
        logic cur_inc;      // skip the current slot
        logic div_start;    // launch quotient of remaining by denomination
        logic cap_take;     // register min(quotient, stock)
        logic cap_prod;     // register denomination * take, lower stock
        logic emit_entry;   // dispense entry, update remaining, next slot
        logic emit_sum;     // request summary
        logic emit_ack;     // load acknowledge
    } t_dp_cmd;

    typedef struct packed {
        logic walk_end;     // slots exhausted or nothing left to pay
        logic can_div;      // current denomination nonzero and not above remaining
        logic div_done;     // quotient ready
        logic out_free;     // output register can take a result
    } t_dp_stat;

endpackage

// ===== src/greedy_change_dispenser.sv =====
// Top level of the greedy change dispenser: controller plus datapath.
// Depends on gcd_pkg, gcd_ctrl, gcd_dp and the assertion macro header.
//
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_stall    i_in_data  (t_in_item)
//  out      output     o_out_valid / i_out_stall  o_out_data (t_out_item)
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A load passes through the acknowledge state before the next input transfer.
// A request skips each unusable slot in the check state and takes each paying
// slot through the bit-serial divider, the multiply and the emit, then closes
// with the summary. One item is worked on at a time; the next is taken once
// its last result sits in the output register. Output stalls hold the walk at
// its next result. Reset is synchronous, active low, and needs no clearing pass.
`include "greedy_change_dispenser_macros.svh"

module greedy_change_dispenser #(
    parameter int NUM_DENOMS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  gcd_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output gcd_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [gcd_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [gcd_pkg::AMT_W-1:0]  i_cfg_data
);
    import gcd_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    gcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    gcd_dp #(
        .NUM_DENOMS (NUM_DENOMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // checks
    `GCD_ASSERT_SAME(a_last_matches_kind, i_clk, i_rst_n, o_out_valid, (o_out_data.last == (o_out_data.kind != KIND_DISPENSE)), "last flag disagrees with result kind")
    `GCD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && !o_in_stall), o_in_stall, "input taken while previous item still in progress")
    `GCD_ASSERT_SAME(a_emit_when_free, i_clk, i_rst_n, (w_cmd.emit_entry || w_cmd.emit_sum || w_cmd.emit_ack), w_stat.out_free, "result issued over an undelivered result")

endmodule

// ===== src/gcd_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on gcd_pkg.
module gcd_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [gcd_pkg::AMT_W-1:0] i_dividend,
    input  logic [gcd_pkg::AMT_W-1:0] i_divisor,
    output logic [gcd_pkg::AMT_W-1:0] o_quot,
    output logic                      o_done
);
    import gcd_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DIV_CW-1:0] r_cnt, n_cnt;
    logic [AMT_W-1:0]  r_q, n_q;
    logic [AMT_W-1:0]  r_r, n_r;
    logic [AMT_W-1:0]  r_d;
    logic [AMT_W:0]    w_trial;
    logic [AMT_W:0]    w_diff;

    // one trial subtraction per cycle
    assign w_trial = {r_r, r_q[AMT_W-1]};
    assign w_diff  = w_trial - {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_r    = '0;
        end else if (r_busy) begin
            if (!w_diff[AMT_W]) begin
                n_r = w_diff[AMT_W-1:0];
                n_q = {r_q[AMT_W-2:0], 1'b1};
            end else begin
                n_r = w_trial[AMT_W-1:0];
                n_q = {r_q[AMT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CW'(AMT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // operands and partial results
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        r_r <= n_r;
        if (i_start) begin
            r_d <= i_divisor;
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

// ===== src/gcd_ctrl.sv =====
// Controller for the greedy change dispenser: sequences loads and the
// denomination walk. Depends on gcd_pkg.
module gcd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_action,
    output logic              o_in_stall,
    input  gcd_pkg::t_dp_stat i_stat,
    output gcd_pkg::t_dp_cmd  o_cmd
);
    import gcd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACK   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_SUM   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_LOAD) begin
                        o_cmd.load_stock = 1'b1;
                        n_state = S_ACK;
                    end else begin
                        o_cmd.start_req = 1'b1;
                        n_state = S_CHECK;
                    end
                end
            end
            S_ACK: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_ack = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                if (i_stat.walk_end) begin
                    n_state = S_SUM;
                end else if (i_stat.can_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.cur_inc = 1'b1;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_take = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.cap_prod = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_entry = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_SUM: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_sum = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/gcd_dp.sv =====
// Datapath for the greedy change dispenser: configuration registers, stock
// counts, walk registers, divider, multiplier and output register.
// Depends on gcd_pkg and gcd_div.
module gcd_dp #(
    parameter int NUM_DENOMS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [gcd_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [gcd_pkg::AMT_W-1:0]  i_cfg_data,
    input  gcd_pkg::t_in_item          i_in_data,
    input  gcd_pkg::t_dp_cmd           i_cmd,
    output gcd_pkg::t_dp_stat          o_stat,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output gcd_pkg::t_out_item         o_out_data
);
    import gcd_pkg::*;

    // slots that hold stock
    localparam int NSLOT = (NUM_DENOMS < SLOTS) ? NUM_DENOMS : SLOTS;
    localparam int IW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;

    logic [AMT_W-1:0]   r_denom [SLOTS];
    logic [2:0]         r_in_use;
    logic [AMT_W-1:0]   r_stock [NSLOT];
    logic [2:0]         r_cursor;
    logic [AMT_W-1:0]   r_rem;
    logic [AMT_W-1:0]   r_take;
    logic [AMT_W-1:0]   r_prod;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic [2:0]         w_limit;
    logic [AMT_W-1:0]   w_d;
    logic [AMT_W-1:0]   w_stock;
    logic [AMT_W-1:0]   w_quot;
    logic               w_div_done;
    logic [2*AMT_W-1:0] w_mul;
    logic [AMT_W-1:0]   w_rem_next;
    logic               w_out_free;
    logic               w_slot_ok;

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_denom[0] <= DENOM_0_RST;
            r_denom[1] <= DENOM_1_RST;
            r_denom[2] <= DENOM_2_RST;
            r_denom[3] <= DENOM_3_RST;
            r_in_use   <= IN_USE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DENOM_0: r_denom[0] <= i_cfg_data;
                CFG_DENOM_1: r_denom[1] <= i_cfg_data;
                CFG_DENOM_2: r_denom[2] <= i_cfg_data;
                CFG_DENOM_3: r_denom[3] <= i_cfg_data;
                CFG_IN_USE:  r_in_use   <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // effective slot count
    assign w_limit = (r_in_use > 3'(NSLOT)) ? 3'(NSLOT) : r_in_use;

    assign w_d     = r_denom[r_cursor[1:0]];
    assign w_stock = r_stock[r_cursor[IW-1:0]];
    assign w_slot_ok = ({1'b0, i_in_data.slot} < 3'(NSLOT));

    // stock counts: load writes, dispense lowers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOT; i++) begin
                r_stock[i] <= '0;
            end
        end else if (i_cmd.load_stock && w_slot_ok) begin
            r_stock[i_in_data.slot[IW-1:0]] <= i_in_data.amount_or_count;
        end else if (i_cmd.cap_prod) begin
            r_stock[r_cursor[IW-1:0]] <= w_stock - r_take;
        end
    end

    // walk cursor, doubles as the slot where the walk stopped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else if (i_cmd.start_req) begin
            r_cursor <= '0;
        end else if (i_cmd.cur_inc || i_cmd.emit_entry) begin
            r_cursor <= r_cursor + 3'd1;
        end
    end

    gcd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rem),
        .i_divisor  (w_d),
        .o_quot     (w_quot),
        .o_done     (w_div_done)
    );

    // take, product and remaining amount; product never exceeds remaining
    assign w_mul      = w_d * r_take;
    assign w_rem_next = r_rem - r_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_req) begin
            r_rem <= i_in_data.amount_or_count;
        end else if (i_cmd.emit_entry) begin
            r_rem <= w_rem_next;
        end
        if (i_cmd.cap_take) begin
            r_take <= (w_quot < w_stock) ? w_quot : w_stock;
        end
        if (i_cmd.cap_prod) begin
            r_prod <= w_mul[AMT_W-1:0];
        end
    end

    // output register
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_entry || i_cmd.emit_sum || i_cmd.emit_ack) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_entry) begin
            r_out_data.kind        <= KIND_DISPENSE;
            r_out_data.denom_value <= w_d;
            r_out_data.piece_count <= r_take;
            r_out_data.remaining   <= w_rem_next;
            r_out_data.last        <= 1'b0;
        end else if (i_cmd.emit_sum) begin
            r_out_data.kind        <= KIND_SUMMARY;
            r_out_data.denom_value <= '0;
            r_out_data.piece_count <= '0;
            r_out_data.remaining   <= r_rem;
            r_out_data.last        <= 1'b1;
        end else if (i_cmd.emit_ack) begin
            r_out_data.kind        <= KIND_LOAD_ACK;
            r_out_data.denom_value <= '0;
            r_out_data.piece_count <= '0;
            r_out_data.remaining   <= '0;
            r_out_data.last        <= 1'b1;
        end
    end

    // status to the controller
    assign o_stat.walk_end = (r_cursor >= w_limit) || (r_rem == '0);
    assign o_stat.can_div  = (w_d != '0) && (w_d <= r_rem);
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for greedy_change_dispenser: loads and payout requests
// are checked field by field against a built-in predictor of the greedy walk.
// Depends on gcd_pkg and the greedy_change_dispenser RTL.
module tb_top;
    import gcd_pkg::*;

    localparam int NUM_DENOMS   = 4;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 400;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out_data;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_IW-1:0]   i_cfg_index = CFG_DENOM_0;
    logic [AMT_W-1:0]    i_cfg_data  = '0;

    // predictor state: configuration copy and stock per slot
    logic [AMT_W-1:0]    denom_val [SLOTS];
    logic [AMT_W-1:0]    stock_left [SLOTS];
    logic [2:0]          slots_used;

    t_in_item            pending_items [$];
    t_out_item           results_due [$];
    int                  mismatches = 0;
    int                  cycle_count = 0;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    bit                  hold_req = 1'b0;
    int                  hold_left = 0;

    greedy_change_dispenser #(
        .NUM_DENOMS (NUM_DENOMS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Work out the results of one accepted item and queue them
    function automatic void predict_payout(input t_in_item item);
        t_out_item        res;
        logic [AMT_W-1:0] owed;
        int unsigned      lim;
        int unsigned      quot;
        int unsigned      take;
        res = '0;
        if (item.action == ACT_LOAD) begin
            if (item.slot < NUM_DENOMS)
                stock_left[item.slot] = item.amount_or_count;
            res.kind = KIND_LOAD_ACK;
            res.last = 1'b1;
            results_due.push_back(res);
            return;
        end
        lim = 32'(slots_used);
        if (lim > SLOTS) lim = SLOTS;
        if (lim > NUM_DENOMS) lim = NUM_DENOMS;
        owed = item.amount_or_count;
        for (int s = 0; s < lim && owed != 0; s++) begin
            // zero-valued slots and those above the amount are passed over
            if (denom_val[s] != 0 && denom_val[s] <= owed) begin
                quot = owed / denom_val[s];
                take = (quot < stock_left[s]) ? quot : stock_left[s];
                stock_left[s] = stock_left[s] - take[AMT_W-1:0];
                owed = owed - denom_val[s] * take[AMT_W-1:0];
                res = '0;
                res.kind        = KIND_DISPENSE;
                res.denom_value = denom_val[s];
                res.piece_count = take[AMT_W-1:0];
                res.remaining   = owed;
                results_due.push_back(res);
            end
        end
        res = '0;
        res.kind      = KIND_SUMMARY;
        res.remaining = owed;
        res.last      = 1'b1;
        results_due.push_back(res);
    endfunction

    function automatic void check_field(input string name, input logic [AMT_W-1:0] want,
                                        input logic [AMT_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Driver: offers queued items, holds a stalled transfer steady
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                predict_payout(i_in_data);
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_items.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer and drives the receiver stall
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_out_data);
                end else begin
                    want = results_due.pop_front();
                    check_field("kind", 16'(want.kind), 16'(o_out_data.kind));
                    check_field("denom_value", want.denom_value, o_out_data.denom_value);
                    check_field("piece_count", want.piece_count, o_out_data.piece_count);
                    check_field("remaining", want.remaining, o_out_data.remaining);
                    check_field("last", 16'(want.last), 16'(o_out_data.last));
                end
            end
            // long hold-off so the block backs up into its input
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_item(input logic act, input logic [1:0] slot_sel,
                            input logic [AMT_W-1:0] value);
        t_in_item item;
        item.action          = act;
        item.slot            = slot_sel;
        item.amount_or_count = value;
        pending_items.push_back(item);
    endtask

    // Random mix of refills and requests, half of the requests built from the current slots
    task automatic queue_random(input int count);
        int unsigned amt;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 35) begin
                add_item(ACT_LOAD, 2'($urandom_range(3)),
                         16'(($urandom_range(9) == 0) ? $urandom_range(65535)
                                                      : $urandom_range(12)));
            end else begin
                case ($urandom_range(3))
                    0: amt = $urandom_range(65535);
                    1: amt = $urandom_range(200);
                    default: begin
                        amt = $urandom_range(49);
                        for (int s = 0; s < SLOTS; s++)
                            amt += denom_val[s] * $urandom_range(3);
                    end
                endcase
                add_item(ACT_REQUEST, 2'($urandom_range(3)), amt[AMT_W-1:0]);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [AMT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_IN_USE)
            slots_used = value[2:0];
        else
            denom_val[idx[1:0]] = value;
    endtask

    task automatic set_denoms(input logic [AMT_W-1:0] d0, input logic [AMT_W-1:0] d1,
                              input logic [AMT_W-1:0] d2, input logic [AMT_W-1:0] d3,
                              input logic [2:0] in_use);
        write_reg(CFG_DENOM_0, d0);
        write_reg(CFG_DENOM_1, d1);
        write_reg(CFG_DENOM_2, d2);
        write_reg(CFG_DENOM_3, d3);
        write_reg(CFG_IN_USE, {13'd0, in_use});
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Stimulus sequence
    initial begin
        denom_val[0] = DENOM_0_RST;
        denom_val[1] = DENOM_1_RST;
        denom_val[2] = DENOM_2_RST;
        denom_val[3] = DENOM_3_RST;
        slots_used   = IN_USE_RST;
        for (int s = 0; s < SLOTS; s++)
            stock_left[s] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset denominations, sender idles lightly, receiver heavily
        send_idle_pct = 15;
        recv_idle_pct = 47;
        add_item(ACT_REQUEST, 2'd0, 16'd0);        // zero amount, empty stock
        add_item(ACT_REQUEST, 2'd3, 16'hFFFF);     // all slots, nothing in stock
        add_item(ACT_LOAD,    2'd0, 16'hFFFF);
        add_item(ACT_LOAD,    2'd1, 16'd0);
        add_item(ACT_LOAD,    2'd2, 16'd3);
        add_item(ACT_LOAD,    2'd3, 16'd1);
        add_item(ACT_REQUEST, 2'd1, 16'd40);       // below every denomination
        add_item(ACT_REQUEST, 2'd0, 16'd1000);     // exact in one piece
        add_item(ACT_REQUEST, 2'd2, 16'hFFFF);     // shortfall
        add_item(ACT_LOAD,    2'd1, 16'hFFFF);
        add_item(ACT_LOAD,    2'd3, 16'hAAAA);
        add_item(ACT_LOAD,    2'd2, 16'h5555);
        add_item(ACT_REQUEST, 2'd0, 16'd1550);
        add_item(ACT_REQUEST, 2'd3, 16'hFFFF);
        add_item(ACT_REQUEST, 2'd1, 16'd0);        // zero amount with stock
        add_item(ACT_REQUEST, 2'd2, 16'd49);
        queue_random(60);
        wait_idle();

        // widest and narrowest values, slot count above the table
        set_denoms(16'hFFFF, 16'd300, 16'd7, 16'd1, 3'd7);
        add_item(ACT_LOAD,    2'd0, 16'd2);
        add_item(ACT_REQUEST, 2'd1, 16'hFFFF);
        queue_random(70);
        wait_idle();

        // zero-valued and unordered slots, roles swapped
        send_idle_pct = 47;
        recv_idle_pct = 15;
        set_denoms(16'd0, 16'd25, 16'd200, 16'd1, 3'd3);
        queue_random(70);
        wait_idle();

        // no slots in use
        set_denoms(16'd1, 16'd2, 16'd3, 16'd5, 3'd0);
        queue_random(20);
        wait_idle();

        // single slot
        set_denoms(16'd10, 16'd5, 16'd2, 16'd1, 3'd1);
        queue_random(40);
        wait_idle();

        // no idling; receiver holds off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_denoms(16'd20, 16'd10, 16'd5, 16'd1, 3'd4);
        hold_req = 1'b1;
        queue_random(80);
        wait_idle();

        set_denoms(DENOM_0_RST, DENOM_1_RST, DENOM_2_RST, DENOM_3_RST, 3'd5);
        queue_random(80);
        wait_idle();

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
